@@ src/smpg_pkg.sv @@
// screen mask pattern generator: shared types, constants and arithmetic helpers
// used by smpg_mod_pipe and screen_mask_pattern_generator_core, no dependencies
package smpg_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned DivBits   = CoordBits + FracBits;
  localparam int unsigned CellBits  = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned RegIdxBits = 2;
  localparam int unsigned DimBits   = 17;

  localparam int unsigned DigCnt = (CoordBits + 1) / 2;
  localparam int unsigned DigW   = 2 * DigCnt;
  localparam int unsigned SumW   = 5;

  localparam logic [8:0] StrengthMin = 9'd13;
  localparam logic [8:0] StrengthMax = 9'd256;
  localparam logic [CellBits-1:0] CellDefault = 16'd1024;

  localparam logic [7:0] CoefScan   = 8'd115;
  localparam logic [7:0] CoefGrScan = 8'd90;
  localparam logic [7:0] CoefGrPhos = 8'd46;
  localparam logic [7:0] CoefGrid   = 8'd141;
  localparam logic [7:0] CoefSub    = 8'd56;
  localparam logic [7:0] CoefDiff   = 8'd51;

  localparam logic [DimBits-1:0] OneQ16 = 17'h10000;
  localparam logic [7:0] ByteFull = 8'd255;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_SCAN   = 3'd1,
    MODE_GRILLE = 3'd2,
    MODE_GRID   = 3'd3,
    MODE_RGB    = 3'd4,
    MODE_BGR    = 3'd5,
    MODE_DIFF   = 3'd6
  } smpg_mode_e;

  typedef enum logic [RegIdxBits-1:0] {
    REG_MODE     = 2'd0,
    REG_STRENGTH = 2'd1,
    REG_CELL_W   = 2'd2,
    REG_CELL_H   = 2'd3
  } smpg_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
  } smpg_pix_in_t;

  typedef struct packed {
    logic [7:0] mask_red;
    logic [7:0] mask_green;
    logic [7:0] mask_blue;
  } smpg_pix_out_t;

  typedef struct packed {
    logic [1:0] col;
    logic       odd_row;
    logic       diag;
  } smpg_side_t;

  // column mod 3 from the sum of base-4 digits
  function automatic logic [1:0] mod3(input logic [CoordBits-1:0] v);
    logic [DigW-1:0] ve;
    logic [SumW-1:0] s;
    ve = DigW'(v);
    s  = '0;
    for (int i = 0; i < DigCnt; i++) begin
      s = s + SumW'(ve[2*i +: 2]);
    end
    if (s >= 5'd24) s = s - 5'd24;
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6)  s = s - 5'd6;
    if (s >= 5'd3)  s = s - 5'd3;
    return s[1:0];
  endfunction

  // one restoring remainder step
  function automatic logic [CellBits-1:0] mod_step(input logic [CellBits-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [CellBits-1:0] d);
    logic [CellBits:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[CellBits-1:0];
  endfunction

  // round a Q1.16 factor to a byte
  function automatic logic [7:0] byte_q16(input logic [DimBits-1:0] f);
    logic [DimBits+8:0] t;
    logic [9:0] v;
    t = {1'b0, f, 8'b0} - (DimBits+9)'(f) + (DimBits+9)'(32'h8000);
    v = t[DimBits+8:16];
    return (v > 10'd255) ? ByteFull : v[7:0];
  endfunction

  // round a Q2.32 factor to a byte
  function automatic logic [7:0] byte_q32(input logic [2*DimBits-1:0] p);
    logic [2*DimBits+7:0] t;
    logic [9:0] v;
    t = {p, 8'b0} - (2*DimBits+8)'(p) + (2*DimBits+8)'(64'h8000_0000);
    v = t[2*DimBits+7:32];
    return (v > 10'd255) ? ByteFull : v[7:0];
  endfunction

endpackage

@@ src/screen_mask_pattern_generator_core.sv @@
// results pass through the one-bit-per-stage cell remainder pipeline, then the output register
// throughput: one transaction per cycle, stalls only where the output side holds back
// reset: mode off, strength 1.0, cell sizes 4.0, pipeline empty; derived mask bytes
// follow a register write through the registered dim factors, grille product and bytes
// depends on smpg_pkg and smpg_mod_pipe
module screen_mask_pattern_generator_core import smpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  smpg_pix_in_t          in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output smpg_pix_out_t         out_data_o
);

  logic [2:0]          mode_q;
  logic [8:0]          strength_q;
  logic [CellBits-1:0] cell_w_q;
  logic [CellBits-1:0] cell_h_q;
  logic [8:0]          strength_sat;

  logic [CellBits-1:0] div_x_q;
  logic [CellBits-1:0] div_y_q;
  logic [DimBits-1:0]  dim_scan_q;
  logic [DimBits-1:0]  dim_gscan_q;
  logic [DimBits-1:0]  dim_phos_q;
  logic [DimBits-1:0]  dim_grid_q;
  logic [DimBits-1:0]  dim_sub_q;
  logic [DimBits-1:0]  dim_diff_q;
  logic [2*DimBits-1:0] grille_prod_q;
  logic [7:0]          byte_scan_q;
  logic [7:0]          byte_gscan_q;
  logic [7:0]          byte_phos_q;
  logic [7:0]          byte_grid_q;
  logic [7:0]          byte_sub_q;
  logic [7:0]          byte_diff_q;
  logic [7:0]          byte_gdim_odd_q;

  logic                pipe_valid;
  logic                pipe_ready;
  logic [CellBits-1:0] rem_x;
  logic [CellBits-1:0] rem_y;
  smpg_side_t          side;

  logic                grid_hit;
  logic [7:0]          full_b;
  logic [7:0]          dimd_b;
  smpg_pix_out_t       out_d;
  smpg_pix_out_t       out_q;
  logic                out_valid_q;

  always_comb begin
    priority if (cfg_data_i[8:0] < StrengthMin) begin
      strength_sat = StrengthMin;
    end else if (cfg_data_i[8:0] > StrengthMax) begin
      strength_sat = StrengthMax;
    end else begin
      strength_sat = cfg_data_i[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      strength_q <= StrengthMax;
      cell_w_q   <= CellDefault;
      cell_h_q   <= CellDefault;
    end else if (cfg_we_i) begin
      unique case (smpg_reg_e'(cfg_index_i))
        REG_MODE:     mode_q     <= cfg_data_i[2:0];
        REG_STRENGTH: strength_q <= strength_sat;
        REG_CELL_W:   cell_w_q   <= cfg_data_i[CellBits-1:0];
        REG_CELL_H:   cell_h_q   <= cfg_data_i[CellBits-1:0];
      endcase
    end
  end

  // derived per-configuration values
  always_ff @(posedge clk_i) begin
    div_x_q <= (cell_w_q == '0) ? CellDefault : cell_w_q;
    div_y_q <= (cell_h_q == '0) ? CellDefault : cell_h_q;

    dim_scan_q  <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefScan);
    dim_gscan_q <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefGrScan);
    dim_phos_q  <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefGrPhos);
    dim_grid_q  <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefGrid);
    dim_sub_q   <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefSub);
    dim_diff_q  <= OneQ16 - DimBits'(strength_q) * DimBits'(CoefDiff);

    grille_prod_q <= (2*DimBits)'(dim_phos_q) * (2*DimBits)'(dim_gscan_q);
    byte_scan_q   <= byte_q16(dim_scan_q);
    byte_gscan_q  <= byte_q16(dim_gscan_q);
    byte_phos_q   <= byte_q16(dim_phos_q);
    byte_grid_q   <= byte_q16(dim_grid_q);
    byte_sub_q    <= byte_q16(dim_sub_q);
    byte_diff_q   <= byte_q16(dim_diff_q);

    byte_gdim_odd_q <= byte_q32(grille_prod_q);
  end

  smpg_mod_pipe u_mod_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_i       (in_data_i),
    .div_x_i     (div_x_q),
    .div_y_i     (div_y_q),
    .out_valid_o (pipe_valid),
    .out_ready_i (pipe_ready),
    .rem_x_o     (rem_x),
    .rem_y_o     (rem_y),
    .side_o      (side)
  );

  assign grid_hit = (rem_x[CellBits-1:FracBits] == '0) || (rem_y[CellBits-1:FracBits] == '0);
  assign full_b   = side.odd_row ? byte_gscan_q : ByteFull;
  assign dimd_b   = side.odd_row ? byte_gdim_odd_q : byte_phos_q;

  always_comb begin
    out_d = '{mask_red: ByteFull, mask_green: ByteFull, mask_blue: ByteFull};
    unique case (mode_q)
      MODE_SCAN: begin
        if (side.odd_row) begin
          out_d = '{mask_red: byte_scan_q, mask_green: byte_scan_q, mask_blue: byte_scan_q};
        end
      end
      MODE_GRILLE: begin
        out_d.mask_red   = (side.col == 2'd0) ? full_b : dimd_b;
        out_d.mask_green = (side.col == 2'd1) ? full_b : dimd_b;
        out_d.mask_blue  = (side.col == 2'd2) ? full_b : dimd_b;
      end
      MODE_GRID: begin
        if (grid_hit) begin
          out_d = '{mask_red: byte_grid_q, mask_green: byte_grid_q, mask_blue: byte_grid_q};
        end
      end
      MODE_RGB: begin
        out_d.mask_red   = (side.col == 2'd0) ? ByteFull : byte_sub_q;
        out_d.mask_green = (side.col == 2'd1) ? ByteFull : byte_sub_q;
        out_d.mask_blue  = (side.col == 2'd2) ? ByteFull : byte_sub_q;
      end
      MODE_BGR: begin
        out_d.mask_red   = (side.col == 2'd2) ? ByteFull : byte_sub_q;
        out_d.mask_green = (side.col == 2'd1) ? ByteFull : byte_sub_q;
        out_d.mask_blue  = (side.col == 2'd0) ? ByteFull : byte_sub_q;
      end
      MODE_DIFF: begin
        if (side.diag) begin
          out_d = '{mask_red: byte_diff_q, mask_green: byte_diff_q, mask_blue: byte_diff_q};
        end
      end
      default: begin
        out_d = '{mask_red: ByteFull, mask_green: ByteFull, mask_blue: ByteFull};
      end
    endcase
  end

  // output register
  assign pipe_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_ready) begin
      out_valid_q <= pipe_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready && pipe_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strength_q >= StrengthMin) && (strength_q <= StrengthMax))
    else $error("strength register outside saturation range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (div_x_q != '0) && (div_y_q != '0))
    else $error("zero cell divisor reached the remainder pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == MODE_OFF) |->
      (out_data_o.mask_red == ByteFull) && (out_data_o.mask_green == ByteFull) &&
      (out_data_o.mask_blue == ByteFull))
    else $error("mask applied with mode off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((mode_q == MODE_SCAN) || (mode_q == MODE_GRID) || (mode_q == MODE_DIFF)) |->
      (out_data_o.mask_red == out_data_o.mask_green) &&
      (out_data_o.mask_green == out_data_o.mask_blue))
    else $error("uniform mode gave unequal channels");

endmodule

@@ src/smpg_mod_pipe.sv @@
// pipelined remainder of the Q12.8 pixel position by the cell sizes, one bit per stage
// depends on smpg_pkg
module smpg_mod_pipe import smpg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smpg_pix_in_t        pix_i,
  input  logic [CellBits-1:0] div_x_i,
  input  logic [CellBits-1:0] div_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CellBits-1:0] rem_x_o,
  output logic [CellBits-1:0] rem_y_o,
  output smpg_side_t          side_o
);

  localparam int unsigned NumStages = DivBits;

  logic                valid_q [NumStages];
  logic                stage_rdy [NumStages+1];
  logic [CellBits-1:0] rem_x_q [NumStages];
  logic [CellBits-1:0] rem_y_q [NumStages];
  smpg_side_t          side_q [NumStages];
  logic [DivBits-1:0]  dv_x_q [NumStages-1];
  logic [DivBits-1:0]  dv_y_q [NumStages-1];

  assign stage_rdy[NumStages] = out_ready_i;
  assign in_ready_o           = stage_rdy[0];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic                vin;
    logic [DivBits-1:0]  dx_in;
    logic [DivBits-1:0]  dy_in;
    logic [CellBits-1:0] rx_in;
    logic [CellBits-1:0] ry_in;
    smpg_side_t          side_in;

    if (k == 0) begin : g_first
      assign vin           = in_valid_i;
      assign dx_in         = {pix_i.pos_x, FracBits'(0)};
      assign dy_in         = {pix_i.pos_y, FracBits'(0)};
      assign rx_in         = '0;
      assign ry_in         = '0;
      assign side_in.col     = mod3(pix_i.pos_x);
      assign side_in.odd_row = pix_i.pos_y[0];
      assign side_in.diag    = pix_i.pos_x[0] ^ pix_i.pos_y[0];
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign dx_in   = dv_x_q[k-1];
      assign dy_in   = dv_y_q[k-1];
      assign rx_in   = rem_x_q[k-1];
      assign ry_in   = rem_y_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_rdy[k]) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[k] && vin) begin
        rem_x_q[k] <= mod_step(rx_in, dx_in[DivBits-1], div_x_i);
        rem_y_q[k] <= mod_step(ry_in, dy_in[DivBits-1], div_y_i);
        side_q[k]  <= side_in;
      end
    end

    if (k < NumStages - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (stage_rdy[k] && vin) begin
          dv_x_q[k] <= {dx_in[DivBits-2:0], 1'b0};
          dv_y_q[k] <= {dy_in[DivBits-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign rem_x_o     = rem_x_q[NumStages-1];
  assign rem_y_o     = rem_y_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

  // remainders stay below their divisors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rem_x_o < div_x_i) && (rem_y_o < div_y_i))
    else $error("smpg_mod_pipe: remainder not below cell size");

  // column phase is always a valid mod 3 value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> side_o.col != 2'd3)
    else $error("smpg_mod_pipe: column phase out of range");

  // a held result is not replaced while the next side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rem_x_o) && $stable(rem_y_o))
    else $error("smpg_mod_pipe: stalled result changed");

endmodule

@@ verif/screen_mask_pattern_generator_core_tb.sv @@
// self-checking testbench for screen_mask_pattern_generator_core: predicts the rgb mask bytes
// of every pixel transaction and compares them in order; depends on smpg_pkg and the rtl
`timescale 1ns / 1ps

module screen_mask_pattern_generator_core_tb;
  import smpg_pkg::*;

  localparam int PIPE_LAT       = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 68;

  localparam int unsigned SCAN_K     = 115;
  localparam int unsigned GR_SCAN_K  = 90;
  localparam int unsigned GR_PHOS_K  = 46;
  localparam int unsigned GRID_K     = 141;
  localparam int unsigned SUB_K      = 56;
  localparam int unsigned DIFF_K     = 51;
  localparam int unsigned ONE_Q16    = 65536;
  localparam int unsigned STR_LO     = 13;
  localparam int unsigned STR_HI     = 256;
  localparam int unsigned CELL_RESET = 1024;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;

  localparam logic [3:0] WR_MODE     = 4'b0001;
  localparam logic [3:0] WR_STRENGTH = 4'b0010;
  localparam logic [3:0] WR_CELLS    = 4'b1100;
  localparam logic [3:0] WR_ALL      = 4'b1111;

  typedef struct {
    smpg_pix_in_t  px;
    smpg_pix_out_t mask;
  } mask_expect_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [RegIdxBits-1:0] cfg_index_i = REG_MODE;
  logic [CfgBits-1:0]    cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  smpg_pix_in_t          in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  smpg_pix_out_t         out_data_o;

  logic [2:0]  cur_mode     = MODE_OFF;
  int unsigned cur_strength = STR_HI;
  int unsigned cur_cell_w   = CELL_RESET;
  int unsigned cur_cell_h   = CELL_RESET;

  mask_expect_t expected_masks[$];
  bit           no_idle        = 1'b0;
  int           err_count      = 0;
  int           masks_checked  = 0;
  int           pixels_sent    = 0;
  int           settings_count = 0;
  int           idle_cycles    = 0;
  int           ready_hold     = 0;

  screen_mask_pattern_generator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // mask prediction

  function automatic longint unsigned dim_factor(input int unsigned coef);
    longint unsigned p;
    p = longint'(cur_strength) * coef;
    return (p >= ONE_Q16) ? 64'd0 : ONE_Q16 - p;
  endfunction

  function automatic logic [7:0] q32_to_byte(input longint unsigned f);
    longint unsigned v;
    v = (f * 255 + 64'h8000_0000) >> 32;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic smpg_pix_out_t predict_mask(input smpg_pix_in_t px);
    int unsigned     x, y, col, cw, ch, fx, fy, lead;
    logic            odd;
    longint unsigned scan, phos;
    logic [7:0]      full, dimd, d, r, g, b;
    x = px.pos_x;
    y = px.pos_y;
    col = x % 3;
    odd = y[0];
    r = 8'd255;
    g = 8'd255;
    b = 8'd255;
    case (cur_mode)
      MODE_SCAN: begin
        if (odd) begin
          d = q32_to_byte(dim_factor(SCAN_K) << 16);
          r = d; g = d; b = d;
        end
      end
      MODE_GRILLE: begin
        scan = odd ? dim_factor(GR_SCAN_K) : 64'(ONE_Q16);
        phos = dim_factor(GR_PHOS_K);
        full = q32_to_byte(scan << 16);
        dimd = q32_to_byte(phos * scan);
        r = (col == 0) ? full : dimd;
        g = (col == 1) ? full : dimd;
        b = (col == 2) ? full : dimd;
      end
      MODE_GRID: begin
        cw = (cur_cell_w != 0) ? cur_cell_w : CELL_RESET;
        ch = (cur_cell_h != 0) ? cur_cell_h : CELL_RESET;
        fx = (x << 8) % cw;
        fy = (y << 8) % ch;
        if (fx < 256 || fy < 256) begin
          d = q32_to_byte(dim_factor(GRID_K) << 16);
          r = d; g = d; b = d;
        end
      end
      MODE_RGB, MODE_BGR: begin
        d = q32_to_byte(dim_factor(SUB_K) << 16);
        lead = (cur_mode == MODE_RGB) ? 0 : 2;
        r = (col == lead) ? 8'd255 : d;
        g = (col == 1) ? 8'd255 : d;
        b = (col == 2 - lead) ? 8'd255 : d;
      end
      MODE_DIFF: begin
        if (((x + y) & 1) != 0) begin
          d = q32_to_byte(dim_factor(DIFF_K) << 16);
          r = d; g = d; b = d;
        end
      end
      default: ;
    endcase
    return '{mask_red: r, mask_green: g, mask_blue: b};
  endfunction

  // shared tasks

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_pixel(input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y);
    int           gap;
    smpg_pix_in_t px;
    px = '{pos_x: x, pos_y: y};
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    expected_masks.push_back('{px: px, mask: predict_mask(px)});
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_masks.size() > 0) @(posedge clk_i);
  endtask

  // caller makes sure the block is idle
  task automatic write_config(input logic [3:0] en, input logic [15:0] mode_v,
                              input logic [15:0] strength_v, input logic [15:0] cw_v,
                              input logic [15:0] ch_v);
    logic [15:0] vals [4];
    int unsigned s;
    vals = '{mode_v, strength_v, cw_v, ch_v};
    for (int i = 0; i < 4; i++) begin
      if (en[i]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= smpg_reg_e'(i);
        cfg_data_i  <= vals[i];
        @(posedge clk_i);
        case (smpg_reg_e'(i))
          REG_MODE: cur_mode = vals[i][2:0];
          REG_STRENGTH: begin
            s = vals[i][8:0];
            if (s < STR_LO) s = STR_LO;
            if (s > STR_HI) s = STR_HI;
            cur_strength = s;
          end
          REG_CELL_W: cur_cell_w = vals[i];
          REG_CELL_H: cur_cell_h = vals[i];
          default: ;
        endcase
      end
    end
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    settings_count++;
  endtask

  function automatic logic [15:0] pick_strength();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd12;
      2: return 16'(STR_LO);
      3: return 16'(STR_HI);
      4: return 16'd257;
      5: return 16'h01FF;
      6: return 16'($urandom);
      default: return 16'($urandom_range(STR_LO, STR_HI));
    endcase
  endfunction

  function automatic logic [15:0] pick_cell();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'd256;
      4: return 16'($urandom);
      default: return 16'($urandom_range(257, 3072));
    endcase
  endfunction

  function automatic logic [CoordBits-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CoordBits'($urandom_range(0, (1 << CoordBits) - 1));
    endcase
  endfunction

  // test tasks

  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    wait_drained();
    // reset strength and cell size seen through the grid pattern
    write_config(WR_MODE, 16'(MODE_GRID), '0, '0, '0);
    send_pixel(12'd4, 12'd5);
    send_pixel(12'd1, 12'd1);
    wait_drained();
  endtask

  task automatic test_mode_sweep();
    for (int m = 1; m < 8; m++) begin
      write_config(WR_MODE, 16'(m), '0, '0, '0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4093, 12'd4095);
      send_pixel(12'd4094, 12'd4094);
      wait_drained();
    end
  endtask

  task automatic test_strength_clamp();
    write_config(WR_MODE | WR_STRENGTH, 16'(MODE_GRILLE), 16'd0, '0, '0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2, 12'd0);
    wait_drained();
    write_config(WR_MODE | WR_STRENGTH, 16'(MODE_BGR), 16'hFFFF, '0, '0);
    send_pixel(12'd0, 12'd3);
    wait_drained();
  endtask

  task automatic test_cell_size_edges();
    write_config(WR_MODE | WR_CELLS, 16'(MODE_GRID), '0, 16'd0, 16'hFFFF);
    send_pixel(12'd4, 12'd300);
    send_pixel(12'd5, 12'd257);
    send_pixel(12'd1, 12'd0);
    wait_drained();
    write_config(WR_CELLS, '0, '0, 16'd1, 16'd65535);
    send_pixel(12'd7, 12'd9);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [15:0] mode_v;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: write_config(WR_ALL, 16'(MODE_GRID), 16'd0, 16'd1, 16'hFFFF);
        1: write_config(WR_ALL, 16'hFFF8 | 16'(MODE_GRILLE), 16'h01FF, 16'd0, 16'd256);
        2: write_config(WR_ALL, 16'(MODE_UNUSED), 16'd257, 16'd768, 16'd0);
        default: begin
          mode_v = 16'($urandom) & 16'hFFF8;
          mode_v[2:0] = 3'($urandom_range(0, 7));
          write_config(WR_ALL, mode_v, pick_strength(), pick_cell(), pick_cell());
        end
      endcase
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((ph == 2 && i == PHASE_ITEMS / 2) || $urandom_range(0, 59) == 0) wait_drained();
        send_pixel(pick_coord(), pick_coord());
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, ordered checking, watchdog

  always @(posedge clk_i) begin : ready_gen
    int h;
    h = ready_hold;
    if (!rst_ni) begin
      h = 0;
    end else if (out_valid_o && out_ready_i) begin
      h = no_idle ? 0 : $urandom_range(0, 3);
    end else if (h > 0) begin
      h--;
    end
    ready_hold  <= h;
    out_ready_i <= rst_ni && (h == 0);
  end

  always @(posedge clk_i) begin : mask_check
    mask_expect_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_masks.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0h", out_data_o));
      end else begin
        e = expected_masks.pop_front();
        if (out_data_o.mask_red !== e.mask.mask_red)
          report_mismatch($sformatf("x=%0d y=%0d mask_red got %0d expected %0d",
                                    e.px.pos_x, e.px.pos_y, out_data_o.mask_red,
                                    e.mask.mask_red));
        if (out_data_o.mask_green !== e.mask.mask_green)
          report_mismatch($sformatf("x=%0d y=%0d mask_green got %0d expected %0d",
                                    e.px.pos_x, e.px.pos_y, out_data_o.mask_green,
                                    e.mask.mask_green));
        if (out_data_o.mask_blue !== e.mask.mask_blue)
          report_mismatch($sformatf("x=%0d y=%0d mask_blue got %0d expected %0d",
                                    e.px.pos_x, e.px.pos_y, out_data_o.mask_blue,
                                    e.mask.mask_blue));
        masks_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_masks.size());
      $display("** screen_mask_pattern_generator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_mode_sweep();
    test_strength_clamp();
    test_cell_size_edges();
    test_random_settings();
    wait_drained();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (expected_masks.size() != 0) report_mismatch("results still outstanding at end");
    $display("covered all eight mode codes over %0d register settings,", settings_count);
    $display("%0d pixels sent and %0d mask results checked, %0d mismatches",
             pixels_sent, masks_checked, err_count);
    if (err_count == 0) begin
      $display("** screen_mask_pattern_generator_core: PASSED **");
    end else begin
      $display("** screen_mask_pattern_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
